[hdl/mfb_pkg.sv]
`timescale 1ns / 1ps

package mfb_pkg;

    // Beat widths on the stream ports
    localparam int IN_TDATA_W  = 64;
    localparam int IN_TUSER_W  = 3;
    localparam int OUT_TDATA_W = 272;

    // Signed coordinate width inside the draw path: an 11-bit corner plus an
    // 11-bit size minus one, with headroom
    localparam int COORD_W = 13;

    // Widths that cover the whole legal range of screen sizes
    localparam int COL_MAX_W   = 8;   // up to 256 columns
    localparam int ROW_MAX_W   = 7;   // up to 128 rows
    localparam int PAGE_MAX_W  = 4;   // up to 16 pages
    localparam int CHUNK_IDX_W = 3;   // up to 8 chunks per page

    // Flush chunk geometry
    localparam int CHUNK_BYTES = 32;
    localparam int BYTE_IDX_W  = 5;
    localparam int CHUNK_W     = CHUNK_BYTES * 8;

    // Command codes
    localparam logic [2:0] CMD_CLEAR   = 3'd0;
    localparam logic [2:0] CMD_PIXEL   = 3'd1;
    localparam logic [2:0] CMD_FILL    = 3'd2;
    localparam logic [2:0] CMD_OUTLINE = 3'd3;
    localparam logic [2:0] CMD_FLUSH   = 3'd4;

    // Clipped span of one rectangle, inclusive bounds
    typedef struct packed {
        logic                 empty;
        logic [COL_MAX_W-1:0] x0;
        logic [COL_MAX_W-1:0] x1;
        logic [ROW_MAX_W-1:0] y0;
        logic [ROW_MAX_W-1:0] y1;
    } span_t;

endpackage

[hdl/mfb_store.sv]
`timescale 1ns / 1ps

module mfb_store #(
    parameter int DEPTH  = 1024,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [7:0]        wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [7:0]        rd_data
);

    logic [7:0] mem [DEPTH];

    // One write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

[hdl/mfb_clip.sv]
`timescale 1ns / 1ps

module mfb_clip #(
    parameter int SCREEN_WIDTH = 128,
    parameter int PAGE_COUNT   = 8
) (
    input  logic signed [mfb_pkg::COORD_W-1:0] rect_x,
    input  logic signed [mfb_pkg::COORD_W-1:0] rect_y,
    input  logic signed [mfb_pkg::COORD_W-1:0] rect_w,
    input  logic signed [mfb_pkg::COORD_W-1:0] rect_h,
    output mfb_pkg::span_t                     span
);

    localparam int EW = mfb_pkg::COORD_W + 1;
    localparam logic signed [EW-1:0] X_LAST = EW'(SCREEN_WIDTH - 1);
    localparam logic signed [EW-1:0] Y_LAST = EW'(PAGE_COUNT * 8 - 1);
    localparam logic signed [EW-1:0] ONE    = EW'(1);
    localparam logic signed [EW-1:0] ZERO   = EW'(0);
    localparam logic signed [mfb_pkg::COORD_W-1:0] MIN_SIZE = mfb_pkg::COORD_W'(1);

    logic signed [EW-1:0] x_beg;
    logic signed [EW-1:0] x_end;
    logic signed [EW-1:0] y_beg;
    logic signed [EW-1:0] y_end;

    // Far corner of the rectangle
    assign x_beg = EW'(rect_x);
    assign y_beg = EW'(rect_y);
    assign x_end = x_beg + EW'(rect_w) - ONE;
    assign y_end = y_beg + EW'(rect_h) - ONE;

    // Clip against the screen; nothing left means an empty span
    always_comb
    begin
        span.empty = (rect_w < MIN_SIZE) || (rect_h < MIN_SIZE)
                  || (x_end < ZERO) || (y_end < ZERO)
                  || (x_beg > X_LAST) || (y_beg > Y_LAST);
        span.x0 = (x_beg < ZERO) ? '0 : x_beg[mfb_pkg::COL_MAX_W-1:0];
        span.y0 = (y_beg < ZERO) ? '0 : y_beg[mfb_pkg::ROW_MAX_W-1:0];
        span.x1 = (x_end > X_LAST) ? X_LAST[mfb_pkg::COL_MAX_W-1:0]
                                   : x_end[mfb_pkg::COL_MAX_W-1:0];
        span.y1 = (y_end > Y_LAST) ? Y_LAST[mfb_pkg::ROW_MAX_W-1:0]
                                   : y_end[mfb_pkg::ROW_MAX_W-1:0];
    end

endmodule

[hdl/monochrome_page_framebuffer_draw_unit.sv]
`timescale 1ns / 1ps

// Channel  Dir  Beat fields (low bit up)
// s_*      in   tuser: command; tdata: pos_x, pos_y, rect_width, rect_height,
//               pixel_on, first_page, last_page
// m_*      out  tdata: page_index, column_start, bytes_0_7, bytes_8_15,
//               bytes_16_23, bytes_24_31; tlast: last_chunk
//
// After reset the store is swept to zero, one byte a cycle, over all
// SCREEN_WIDTH*PAGE_COUNT bytes (1024 by default) with s_tready low; a clear
// command takes the same sweep. A pixel is clipped, then its store byte is
// read and written back. A rectangle is clipped once per side, then each
// touched store byte is read, then written back. A flush reads each 32-byte
// chunk one store byte at a time; a chunk waits in the output register while
// m_tready is low and the next chunk is gathered behind it.
module monochrome_page_framebuffer_draw_unit #(
    parameter int SCREEN_WIDTH = 128,
    parameter int PAGE_COUNT   = 8
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // pos_x, pos_y, rect_width, rect_height, pixel_on, first_page, last_page
    input  logic [mfb_pkg::IN_TDATA_W-1:0]   s_tdata,
    // command
    input  logic [mfb_pkg::IN_TUSER_W-1:0]   s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // page_index, column_start, bytes_0_7, bytes_8_15, bytes_16_23, bytes_24_31
    output logic [mfb_pkg::OUT_TDATA_W-1:0]  m_tdata,
    output logic                             m_tlast
);

    localparam int DEPTH  = SCREEN_WIDTH * PAGE_COUNT;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CPP    = (SCREEN_WIDTH + mfb_pkg::CHUNK_BYTES - 1) / mfb_pkg::CHUNK_BYTES;
    localparam int CW     = mfb_pkg::COORD_W;
    localparam int PW     = mfb_pkg::PAGE_MAX_W;
    localparam int XW     = mfb_pkg::COL_MAX_W;
    localparam int RW     = mfb_pkg::ROW_MAX_W;
    localparam int KW     = mfb_pkg::BYTE_IDX_W;
    localparam int NW     = mfb_pkg::CHUNK_IDX_W;

    localparam logic [ADDR_W-1:0] CLR_LAST   = ADDR_W'(DEPTH - 1);
    localparam logic [NW-1:0]     CHUNK_LAST = NW'(CPP - 1);
    localparam logic [KW-1:0]     K_LAST     = KW'(mfb_pkg::CHUNK_BYTES - 1);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RSEL,
        ST_RD,
        ST_WR,
        ST_FRD,
        ST_FEND
    } state_t;

    state_t                       state_reg, state_next;
    logic [2:0]                   cmd_reg, cmd_next;
    logic signed [10:0]           x_reg, x_next;
    logic signed [10:0]           y_reg, y_next;
    logic signed [10:0]           w_reg, w_next;
    logic signed [10:0]           h_reg, h_next;
    logic                         on_reg, on_next;
    logic [1:0]                   sub_reg, sub_next;
    mfb_pkg::span_t               span_reg, span_next;
    logic [PW-1:0]                page_reg, page_next;
    logic [XW-1:0]                col_reg, col_next;
    logic [PW-1:0]                fl_last_reg, fl_last_next;
    logic [NW-1:0]                chunk_reg, chunk_next;
    logic [KW-1:0]                k_reg, k_next;
    logic [ADDR_W-1:0]            clr_reg, clr_next;
    logic                         rd_vld_reg, rd_vld_next;
    logic                         rd_ok_reg, rd_ok_next;
    logic [KW-1:0]                rd_k_reg, rd_k_next;
    logic [mfb_pkg::CHUNK_W-1:0]  buf_reg, buf_next;
    logic                         m_tvalid_reg, m_tvalid_next;
    logic [mfb_pkg::OUT_TDATA_W-1:0] m_tdata_reg, m_tdata_next;
    logic                         m_tlast_reg, m_tlast_next;

    // Input beat fields
    logic [2:0]         in_cmd;
    logic signed [10:0] in_x;
    logic signed [10:0] in_y;
    logic signed [10:0] in_w;
    logic signed [10:0] in_h;
    logic               in_on;
    logic signed [7:0]  in_first;
    logic signed [7:0]  in_last;
    logic signed [8:0]  first_c;
    logic signed [8:0]  last_c;
    logic               flush_empty;

    // Shared clip unit inputs
    logic signed [CW-1:0] cx;
    logic signed [CW-1:0] cy;
    logic signed [CW-1:0] cw;
    logic signed [CW-1:0] ch;
    mfb_pkg::span_t       clip_span;

    // Store port
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [7:0]        wr_data;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic [7:0]        rd_data;

    logic [ADDR_W-1:0] draw_addr;
    logic [ADDR_W-1:0] flush_addr;
    logic [XW-1:0]     flush_col;
    logic              flush_ok;
    logic [2:0]        bit_lo;
    logic [2:0]        bit_hi;
    logic [7:0]        mask;
    logic [7:0]        rmw_data;
    logic              more_subs;
    logic              out_free;
    logic              chunk_is_last;
    logic [XW-1:0]     chunk_start;

    function automatic logic [ADDR_W-1:0] addr_of(input logic [PW-1:0] page,
                                                  input logic [XW-1:0] col);
        addr_of = ADDR_W'(int'(page) * SCREEN_WIDTH + int'(col));
    endfunction

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

    // Unpack the input beat
    assign in_cmd   = s_tuser;
    assign in_x     = s_tdata[10:0];
    assign in_y     = s_tdata[21:11];
    assign in_w     = s_tdata[32:22];
    assign in_h     = s_tdata[43:33];
    assign in_on    = s_tdata[44];
    assign in_first = s_tdata[52:45];
    assign in_last  = s_tdata[60:53];

    // Flush page range clamp
    assign first_c     = (in_first < 0) ? 9'sd0 : 9'(in_first);
    assign last_c      = (in_last > PAGE_COUNT - 1) ? 9'(PAGE_COUNT - 1) : 9'(in_last);
    assign flush_empty = (first_c > last_c);

    // Pick the rectangle for the current side of the command
    always_comb
    begin
        cx = CW'(x_reg);
        cy = CW'(y_reg);
        cw = CW'(w_reg);
        ch = CW'(h_reg);
        case (cmd_reg)
            mfb_pkg::CMD_PIXEL:
            begin
                cw = CW'(1);
                ch = CW'(1);
            end
            mfb_pkg::CMD_OUTLINE:
            begin
                case (sub_reg)
                    2'd0:
                    begin
                        ch = CW'(1);
                    end
                    2'd1:
                    begin
                        cy = CW'(y_reg) + CW'(h_reg) - CW'(1);
                        ch = CW'(1);
                    end
                    2'd2:
                    begin
                        cw = CW'(1);
                    end
                    default:
                    begin
                        cx = CW'(x_reg) + CW'(w_reg) - CW'(1);
                        cw = CW'(1);
                    end
                endcase
            end
            default:
            begin
            end
        endcase
    end

    mfb_clip #(
        .SCREEN_WIDTH(SCREEN_WIDTH),
        .PAGE_COUNT  (PAGE_COUNT)
    ) u_clip (
        .rect_x(cx),
        .rect_y(cy),
        .rect_w(cw),
        .rect_h(ch),
        .span  (clip_span)
    );

    // Row mask of the current page inside the span
    assign bit_lo   = (page_reg == span_reg.y0[RW-1:3]) ? span_reg.y0[2:0] : 3'd0;
    assign bit_hi   = (page_reg == span_reg.y1[RW-1:3]) ? span_reg.y1[2:0] : 3'd7;
    assign mask     = (8'hFF << bit_lo) & (8'hFF >> (3'd7 - bit_hi));
    assign rmw_data = on_reg ? (rd_data | mask) : (rd_data & ~mask);

    // Store addressing
    assign draw_addr   = addr_of(page_reg, col_reg);
    assign flush_col   = {chunk_reg, k_reg};
    assign flush_addr  = addr_of(page_reg, flush_col);
    assign flush_ok    = ({1'b0, flush_col} < (XW + 1)'(SCREEN_WIDTH));

    assign wr_en   = (state_reg == ST_CLEAR) || (state_reg == ST_WR);
    assign wr_addr = (state_reg == ST_CLEAR) ? clr_reg : draw_addr;
    assign wr_data = (state_reg == ST_CLEAR) ? 8'd0 : rmw_data;
    assign rd_en   = (state_reg == ST_RD) || (state_reg == ST_FRD);
    assign rd_addr = (state_reg == ST_RD) ? draw_addr : flush_addr;

    mfb_store #(
        .DEPTH (DEPTH),
        .ADDR_W(ADDR_W)
    ) u_store (
        .clk    (clk),
        .wr_en  (wr_en),
        .wr_addr(wr_addr),
        .wr_data(wr_data),
        .rd_en  (rd_en),
        .rd_addr(rd_addr),
        .rd_data(rd_data)
    );

    assign more_subs     = (cmd_reg == mfb_pkg::CMD_OUTLINE) && (sub_reg != 2'd3);
    assign out_free      = !m_tvalid_reg || m_tready;
    assign chunk_is_last = (page_reg == fl_last_reg) && (chunk_reg == CHUNK_LAST);
    assign chunk_start   = {chunk_reg, {KW{1'b0}}};

    // Sequencer next state
    always_comb
    begin
        state_next    = state_reg;
        cmd_next      = cmd_reg;
        x_next        = x_reg;
        y_next        = y_reg;
        w_next        = w_reg;
        h_next        = h_reg;
        on_next       = on_reg;
        sub_next      = sub_reg;
        span_next     = span_reg;
        page_next     = page_reg;
        col_next      = col_reg;
        fl_last_next  = fl_last_reg;
        chunk_next    = chunk_reg;
        k_next        = k_reg;
        clr_next      = clr_reg;
        buf_next      = buf_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        m_tlast_next  = m_tlast_reg;

        // Flush read data lands in the cycle after its address
        rd_vld_next = (state_reg == ST_FRD);
        rd_k_next   = k_reg;
        rd_ok_next  = flush_ok;
        if (rd_vld_reg)
        begin
            buf_next[rd_k_reg*8 +: 8] = rd_ok_reg ? rd_data : 8'd0;
        end

        if (m_tvalid_reg && m_tready)
        begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            ST_CLEAR:
            begin
                if (clr_reg == CLR_LAST)
                begin
                    clr_next   = '0;
                    state_next = ST_IDLE;
                end
                else
                begin
                    clr_next = clr_reg + 1'b1;
                end
            end
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd_next = in_cmd;
                    x_next   = in_x;
                    y_next   = in_y;
                    w_next   = in_w;
                    h_next   = in_h;
                    on_next  = in_on;
                    sub_next = 2'd0;
                    case (in_cmd)
                        mfb_pkg::CMD_CLEAR:
                        begin
                            state_next = ST_CLEAR;
                        end
                        mfb_pkg::CMD_PIXEL, mfb_pkg::CMD_FILL, mfb_pkg::CMD_OUTLINE:
                        begin
                            state_next = ST_RSEL;
                        end
                        mfb_pkg::CMD_FLUSH:
                        begin
                            if (!flush_empty)
                            begin
                                page_next    = first_c[PW-1:0];
                                fl_last_next = last_c[PW-1:0];
                                chunk_next   = '0;
                                k_next       = '0;
                                state_next   = ST_FRD;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_RSEL:
            begin
                span_next = clip_span;
                if (clip_span.empty)
                begin
                    if (more_subs)
                    begin
                        sub_next = sub_reg + 1'b1;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
                else
                begin
                    page_next  = clip_span.y0[RW-1:3];
                    col_next   = clip_span.x0;
                    state_next = ST_RD;
                end
            end
            ST_RD:
            begin
                state_next = ST_WR;
            end
            ST_WR:
            begin
                state_next = ST_RD;
                if (col_reg == span_reg.x1)
                begin
                    col_next = span_reg.x0;
                    if (page_reg == span_reg.y1[RW-1:3])
                    begin
                        if (more_subs)
                        begin
                            sub_next   = sub_reg + 1'b1;
                            state_next = ST_RSEL;
                        end
                        else
                        begin
                            state_next = ST_IDLE;
                        end
                    end
                    else
                    begin
                        page_next = page_reg + 1'b1;
                    end
                end
                else
                begin
                    col_next = col_reg + 1'b1;
                end
            end
            ST_FRD:
            begin
                k_next = k_reg + 1'b1;
                if (k_reg == K_LAST)
                begin
                    state_next = ST_FEND;
                end
            end
            ST_FEND:
            begin
                if (!rd_vld_reg && out_free)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {{(mfb_pkg::OUT_TDATA_W - mfb_pkg::CHUNK_W - 10){1'b0}},
                                     buf_reg, chunk_start[6:0], 3'(page_reg)};
                    m_tlast_next  = chunk_is_last;
                    k_next        = '0;
                    if (chunk_is_last)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        state_next = ST_FRD;
                        if (chunk_reg == CHUNK_LAST)
                        begin
                            chunk_next = '0;
                            page_next  = page_reg + 1'b1;
                        end
                        else
                        begin
                            chunk_next = chunk_reg + 1'b1;
                        end
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLEAR;
            cmd_reg      <= '0;
            x_reg        <= '0;
            y_reg        <= '0;
            w_reg        <= '0;
            h_reg        <= '0;
            on_reg       <= 1'b0;
            sub_reg      <= '0;
            span_reg     <= '0;
            page_reg     <= '0;
            col_reg      <= '0;
            fl_last_reg  <= '0;
            chunk_reg    <= '0;
            k_reg        <= '0;
            clr_reg      <= '0;
            rd_vld_reg   <= 1'b0;
            rd_ok_reg    <= 1'b0;
            rd_k_reg     <= '0;
            buf_reg      <= '0;
            m_tvalid_reg <= 1'b0;
            m_tdata_reg  <= '0;
            m_tlast_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            cmd_reg      <= cmd_next;
            x_reg        <= x_next;
            y_reg        <= y_next;
            w_reg        <= w_next;
            h_reg        <= h_next;
            on_reg       <= on_next;
            sub_reg      <= sub_next;
            span_reg     <= span_next;
            page_reg     <= page_next;
            col_reg      <= col_next;
            fl_last_reg  <= fl_last_next;
            chunk_reg    <= chunk_next;
            k_reg        <= k_next;
            clr_reg      <= clr_next;
            rd_vld_reg   <= rd_vld_next;
            rd_ok_reg    <= rd_ok_next;
            rd_k_reg     <= rd_k_next;
            buf_reg      <= buf_next;
            m_tvalid_reg <= m_tvalid_next;
            m_tdata_reg  <= m_tdata_next;
            m_tlast_reg  <= m_tlast_next;
        end
    end

endmodule
